// ===== hdl/incpid_pkg.sv =====
// ----------------------------------------------------------------------------
// incpid_pkg
// Widths, register indexes, reset values and divide constants for the
// incremental PID speed controller.
// ----------------------------------------------------------------------------
`default_nettype none

package incpid_pkg;

  localparam int SPEED_W  = 16;
  localparam int ERR_W    = 17;
  localparam int D1_W     = 18;
  localparam int D2_W     = 19;
  localparam int GAIN_W   = 15;
  localparam int P_W      = GAIN_W + 1 + D1_W;
  localparam int I_W      = GAIN_W + 1 + ERR_W;
  localparam int D_W      = GAIN_W + 1 + D2_W;
  localparam int CHANGE_W = 36;
  localparam int CLIP_W   = 23;
  localparam int RECIP_W  = 24;
  localparam int PROD_W   = CLIP_W + RECIP_W;
  localparam int RECIP_SH = 30;
  localparam int QUOT_W   = 16;
  localparam int ACC_W    = 16;
  localparam int SUM_W    = 18;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_OUTPUT_LIMIT
  } cfg_reg_t;

  localparam logic [GAIN_W-1:0] GAIN_P_RESET       = 15'd3000;
  localparam logic [GAIN_W-1:0] GAIN_I_RESET       = 15'd50;
  localparam logic [GAIN_W-1:0] GAIN_D_RESET       = 15'd50;
  localparam logic [GAIN_W-1:0] OUTPUT_LIMIT_RESET = 15'd10000;

  // Any change of at least this size saturates the output, so clip it here.
  localparam logic [CLIP_W-1:0]  CLIP_MAX   = 23'd6553599;
  // ceil(2^30 / 100): exact floor quotient for every clipped magnitude.
  localparam logic [RECIP_W-1:0] RECIP_MUL  = 24'd10737419;

endpackage

`default_nettype wire

// ===== hdl/incremental_pid_speed_controller_core.sv =====
// ----------------------------------------------------------------------------
// incremental_pid_speed_controller_core
// Velocity-form PID for one wheel: error history, weighted change divided by
// 100 toward zero, saturating accumulator, direction and PWM magnitude.
// ----------------------------------------------------------------------------
// The core takes one speed request per clock cycle while the output is not
// stalled and returns each result through a six-register pipeline: error and
// differences, three gain multipliers, change sum, magnitude clip, reciprocal
// multiply for the divide by 100, and the add-and-clamp of the accumulator,
// which is the only loop. The whole pipeline holds while the output register
// waits. Gains and the limit are written through cfg_write, cfg_index and
// cfg_data and must only change while no request is in flight.
`default_nettype none

module incremental_pid_speed_controller_core
  import incpid_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [GAIN_W-1:0]        cfg_data,
  input  wire logic                     in_valid,
  output      logic                     in_ready,
  input  wire logic signed [SPEED_W-1:0] target_speed,
  input  wire logic signed [SPEED_W-1:0] measured_speed,
  output      logic                     out_valid,
  input  wire logic                     out_ready,
  output      logic                     forward,
  output      logic [GAIN_W-1:0]        drive_magnitude
);

  logic [GAIN_W-1:0] gain_p;
  logic [GAIN_W-1:0] gain_i;
  logic [GAIN_W-1:0] gain_d;
  logic [GAIN_W-1:0] output_limit;

  logic signed [ERR_W-1:0] previous_error;
  logic signed [D1_W-1:0]  error_step;
  logic signed [ACC_W-1:0] accumulated_output;

  logic advance;
  logic accept;
  logic v1, v2, v3, v4, v5;

  logic signed [ERR_W-1:0] err_next;
  logic signed [D1_W-1:0]  d1_next;
  logic signed [D2_W-1:0]  d2_next;
  logic signed [ERR_W-1:0] err_r;
  logic signed [D1_W-1:0]  d1_r;
  logic signed [D2_W-1:0]  d2_r;

  logic signed [P_W-1:0] p_term;
  logic signed [I_W-1:0] i_term;
  logic signed [D_W-1:0] d_term;

  logic signed [CHANGE_W-1:0] change;
  logic [CHANGE_W-1:0]        change_abs;
  logic                       neg4;
  logic [CLIP_W-1:0]          clip_mag;
  logic [CLIP_W-1:0]          clip_next;

  logic [PROD_W-1:0] prod;
  logic              neg5;
  logic [QUOT_W-1:0] quot;

  logic signed [QUOT_W:0]  quot_s;
  logic signed [SUM_W-1:0] acc_sum;
  logic signed [SUM_W-1:0] limit_s;
  logic signed [SUM_W-1:0] acc_next;
  logic signed [SUM_W-1:0] acc_abs;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p       <= GAIN_P_RESET;
      gain_i       <= GAIN_I_RESET;
      gain_d       <= GAIN_D_RESET;
      output_limit <= OUTPUT_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GAIN_P:       gain_p       <= cfg_data;
        REG_GAIN_I:       gain_i       <= cfg_data;
        REG_GAIN_D:       gain_d       <= cfg_data;
        REG_OUTPUT_LIMIT: output_limit <= cfg_data;
        default:          ;
      endcase
    end
  end

  always_comb begin
    err_next = ERR_W'(target_speed) - ERR_W'(measured_speed);
    d1_next  = D1_W'(err_next) - D1_W'(previous_error);
    d2_next  = D2_W'(d1_next) - D2_W'(error_step);
  end

  always_comb begin
    change_abs = change[CHANGE_W-1] ? CHANGE_W'(-change) : CHANGE_W'(change);
    clip_next  = (change_abs > CHANGE_W'(CLIP_MAX)) ? CLIP_MAX : change_abs[CLIP_W-1:0];
    prod       = PROD_W'(clip_mag) * PROD_W'(RECIP_MUL);
  end

  always_comb begin
    quot_s   = neg5 ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    acc_sum  = SUM_W'(accumulated_output) + SUM_W'(quot_s);
    limit_s  = $signed({{(SUM_W-GAIN_W){1'b0}}, output_limit});
    if (acc_sum > limit_s) begin
      acc_next = limit_s;
    end else if (acc_sum < -limit_s) begin
      acc_next = -limit_s;
    end else begin
      acc_next = acc_sum;
    end
    acc_abs = acc_next[SUM_W-1] ? -acc_next : acc_next;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      v1                 <= 1'b0;
      v2                 <= 1'b0;
      v3                 <= 1'b0;
      v4                 <= 1'b0;
      v5                 <= 1'b0;
      out_valid          <= 1'b0;
      previous_error     <= '0;
      error_step         <= '0;
      accumulated_output <= '0;
    end else if (advance) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      out_valid <= v5;
      if (accept) begin
        previous_error <= err_next;
        error_step     <= d1_next;
      end
      if (v5) begin
        accumulated_output <= ACC_W'(acc_next);
      end
    end
  end

  // Payload pipeline
  always_ff @(posedge clk) begin
    if (advance) begin
      err_r           <= err_next;
      d1_r            <= d1_next;
      d2_r            <= d2_next;
      p_term          <= P_W'($signed({1'b0, gain_p})) * P_W'(d1_r);
      i_term          <= I_W'($signed({1'b0, gain_i})) * I_W'(err_r);
      d_term          <= D_W'($signed({1'b0, gain_d})) * D_W'(d2_r);
      change          <= CHANGE_W'(p_term) + CHANGE_W'(i_term) + CHANGE_W'(d_term);
      neg4            <= change[CHANGE_W-1];
      clip_mag        <= clip_next;
      neg5            <= neg4;
      quot            <= prod[RECIP_SH+QUOT_W-1:RECIP_SH];
      forward         <= !acc_next[SUM_W-1];
      drive_magnitude <= acc_abs[GAIN_W-1:0];
    end
  end

`ifndef SYNTH
  a_reverse_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !forward |-> drive_magnitude != '0)
    else $error("reverse drive with zero magnitude");

  a_clip_bound: assert property (@(posedge clk) disable iff (rst)
    v5 |-> clip_mag <= CLIP_MAX)
    else $error("clipped change magnitude out of range");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v1)
    else $error("accepted request did not enter the pipeline");

  a_last_stage_out: assert property (@(posedge clk) disable iff (rst)
    v5 && advance |=> out_valid)
    else $error("finished request did not reach the output");

  a_stall_holds_acc: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(accumulated_output))
    else $error("accumulator moved during a stall");
`endif

endmodule

`default_nettype wire

// ===== tb/pid_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_checker
// Watches the register port and both request channels of the speed
// controller. It keeps its own copy of the gains, the limit, the error history
// and the accumulated drive. Each accepted speed request produces one expected
// drive command. Each accepted command is checked against the oldest one.
// ----------------------------------------------------------------------------
module pid_checker
  import incpid_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  cfg_reg_t                  cfg_index,
  input  logic [GAIN_W-1:0]         cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [SPEED_W-1:0] target_speed,
  input  logic signed [SPEED_W-1:0] measured_speed,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic                      forward,
  input  logic [GAIN_W-1:0]         drive_magnitude,
  output int                        mismatches,
  output int                        pending
);

  typedef struct packed {
    logic              fwd;
    logic [GAIN_W-1:0] mag;
  } drive_cmd_t;

  logic [GAIN_W-1:0]        kp;
  logic [GAIN_W-1:0]        ki;
  logic [GAIN_W-1:0]        kd;
  logic [GAIN_W-1:0]        drive_limit;
  logic signed [ERR_W-1:0]  err_last;
  logic signed [ERR_W-1:0]  err_prior;
  logic signed [ACC_W-1:0]  drive_acc;
  drive_cmd_t               drive_expected[$];
  drive_cmd_t               want_cmd;
  int                       fail_cnt = 0;

  function automatic drive_cmd_t pid_update(input logic signed [SPEED_W-1:0] tgt,
                                            input logic signed [SPEED_W-1:0] meas);
    longint     err;
    longint     e1;
    longint     e2;
    longint     d1;
    longint     d2;
    longint     change;
    longint     acc;
    longint     lim;
    longint     mag;
    drive_cmd_t cmd;
    err = longint'(tgt) - longint'(meas);
    e1 = longint'(err_last);
    e2 = longint'(err_prior);
    d1 = err - e1;
    d2 = d1 - (e1 - e2);
    change = longint'(kp) * d1 + longint'(ki) * err + longint'(kd) * d2;
    lim = longint'(drive_limit);
    // divide truncates toward zero
    acc = longint'(drive_acc) + change / 100;
    if (acc > lim)
      acc = lim;
    else if (acc < -lim)
      acc = -lim;
    err_prior = err_last;
    err_last = err[ERR_W-1:0];
    drive_acc = acc[ACC_W-1:0];
    mag = (acc < 0) ? -acc : acc;
    cmd.fwd = (acc >= 0);
    cmd.mag = mag[GAIN_W-1:0];
    return cmd;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      kp = GAIN_P_RESET;
      ki = GAIN_I_RESET;
      kd = GAIN_D_RESET;
      drive_limit = OUTPUT_LIMIT_RESET;
      err_last = '0;
      err_prior = '0;
      drive_acc = '0;
      drive_expected.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_GAIN_P:       kp = cfg_data;
          REG_GAIN_I:       ki = cfg_data;
          REG_GAIN_D:       kd = cfg_data;
          REG_OUTPUT_LIMIT: drive_limit = cfg_data;
          default:          ;
        endcase
      end
      if (in_valid && in_ready)
        drive_expected.push_back(pid_update(target_speed, measured_speed));
      if (out_valid && out_ready) begin
        if (drive_expected.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual forward=%0b magnitude=%0d",
                   $time, forward, drive_magnitude);
          fail_cnt++;
        end else begin
          want_cmd = drive_expected.pop_front();
          if (forward !== want_cmd.fwd) begin
            $display("%0t: forward mismatch: expected %0b, actual %0b",
                     $time, want_cmd.fwd, forward);
            fail_cnt++;
          end
          if (drive_magnitude !== want_cmd.mag) begin
            $display("%0t: drive_magnitude mismatch: expected %0d, actual %0d",
                     $time, want_cmd.mag, drive_magnitude);
            fail_cnt++;
          end
        end
      end
    end
    mismatches <= fail_cnt;
    pending <= drive_expected.size();
  end

endmodule

// ===== tb/tb_incremental_pid_speed_controller_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_incremental_pid_speed_controller_core
// Drives speed requests and register writes into the PID core under random
// idling on both channels. A directed part covers the speed extremes, maximum
// and zero gains, a zero limit and a lowered limit. Random phases follow, each
// with its own register setting. The checker predicts every drive command.
// ----------------------------------------------------------------------------
module tb_incremental_pid_speed_controller_core;
  import incpid_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 194;
  localparam int NUM_PHASES     = 8;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  cfg_reg_t                  cfg_index = REG_GAIN_P;
  logic [GAIN_W-1:0]         cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [SPEED_W-1:0] target_speed = '0;
  logic signed [SPEED_W-1:0] measured_speed = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      forward;
  logic [GAIN_W-1:0]         drive_magnitude;

  int                        mismatches;
  int                        pending;
  int                        quiet_cycles = 0;
  int                        ready_hold = 0;
  int                        ready_roll;
  bit                        steady = 1'b0;
  logic signed [SPEED_W-1:0] setpoint = '0;

  always #6 clk = ~clk;

  incremental_pid_speed_controller_core u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .target_speed    (target_speed),
    .measured_speed  (measured_speed),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .forward         (forward),
    .drive_magnitude (drive_magnitude)
  );

  pid_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .target_speed    (target_speed),
    .measured_speed  (measured_speed),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .forward         (forward),
    .drive_magnitude (drive_magnitude),
    .mismatches      (mismatches),
    .pending         (pending)
  );

  // stall the result channel
  always @(negedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 55) begin
        out_ready <= 1'b1;
        ready_hold <= $urandom_range(0, 8);
      end else if (ready_roll < 90) begin
        out_ready <= 1'b0;
        ready_hold <= $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b0;
        ready_hold <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60)
      return 0;
    else if (roll < 90)
      return $urandom_range(1, 3);
    else if (roll < 97)
      return $urandom_range(4, 10);
    else
      return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [SPEED_W-1:0] pick_edge();
    case ($urandom_range(0, 4))
      0:       return 16'sh8000;
      1:       return -16'sd1;
      2:       return 16'sd0;
      3:       return 16'sd1;
      default: return 16'sh7fff;
    endcase
  endfunction

  task automatic send_speed(input logic signed [SPEED_W-1:0] tgt,
                            input logic signed [SPEED_W-1:0] meas,
                            input int gap);
    @(negedge clk);
    in_valid <= 1'b1;
    target_speed <= tgt;
    measured_speed <= meas;
    do @(posedge clk); while (!in_ready);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [GAIN_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic apply_gains(input logic [GAIN_W-1:0] gp, input logic [GAIN_W-1:0] gi,
                             input logic [GAIN_W-1:0] gd, input logic [GAIN_W-1:0] lim);
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_OUTPUT_LIMIT, lim);
  endtask

  task automatic next_sample(output logic signed [SPEED_W-1:0] tgt,
                             output logic signed [SPEED_W-1:0] meas);
    int mode;
    mode = $urandom_range(0, 9);
    if (mode <= 5) begin
      // track a drifting setpoint with small error
      setpoint = setpoint + 16'(int'($urandom_range(0, 40)) - 20);
      tgt = setpoint;
      meas = setpoint + 16'(int'($urandom_range(0, 400)) - 200);
    end else if (mode <= 7) begin
      tgt = 16'($urandom);
      meas = 16'($urandom);
    end else if (mode == 8) begin
      tgt = pick_edge();
      meas = pick_edge();
    end else begin
      // step the setpoint
      meas = setpoint + 16'(int'($urandom_range(0, 60)) - 30);
      setpoint = 16'($urandom);
      tgt = setpoint;
    end
  endtask

  initial begin
    logic signed [SPEED_W-1:0] tgt;
    logic signed [SPEED_W-1:0] meas;
    int pause_at;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset gains: zero, opposite extremes, small errors
    send_speed(16'sd0, 16'sd0, 0);
    send_speed(16'sh7fff, 16'sh8000, 1);
    send_speed(16'sh8000, 16'sh7fff, 0);
    send_speed(16'sh8000, 16'sh7fff, 2);
    send_speed(16'sh7fff, 16'sh7fff, 0);
    send_speed(16'sh8000, 16'sh8000, 0);
    send_speed(16'sd100, 16'sd90, 0);
    send_speed(16'sd100, 16'sd95, 3);
    send_speed(16'sd100, 16'sd100, 0);
    send_speed(16'sd0, 16'sd1, 0);
    send_speed(-16'sd1, 16'sd0, 0);
    wait_idle();

    // maximum gains and limit
    apply_gains(15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff);
    send_speed(16'sh7fff, 16'sh8000, 0);
    send_speed(16'sh8000, 16'sh7fff, 0);
    send_speed(16'sh7fff, 16'sh8000, 0);
    send_speed(16'sd0, 16'sd0, 0);
    wait_idle();

    // zero limit forces the drive to zero
    write_reg(REG_OUTPUT_LIMIT, 15'd0);
    send_speed(16'sd500, 16'sd0, 0);
    send_speed(-16'sd500, 16'sd0, 0);
    wait_idle();

    // saturate high, then lower the limit and hold the error
    apply_gains(GAIN_P_RESET, GAIN_I_RESET, GAIN_D_RESET, 15'h7fff);
    send_speed(16'sh7fff, 16'sh8000, 0);
    wait_idle();
    write_reg(REG_OUTPUT_LIMIT, 15'd1000);
    send_speed(16'sh7fff, 16'sh8000, 0);
    wait_idle();

    // zero gains keep the drive where it is
    apply_gains(15'd0, 15'd0, 15'd0, 15'd20000);
    send_speed(16'sd123, -16'sd45, 0);
    send_speed(16'sd0, 16'sd0, 0);
    wait_idle();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      steady = (phase == 6);
      case (phase)
        0: apply_gains(GAIN_P_RESET, GAIN_I_RESET, GAIN_D_RESET, OUTPUT_LIMIT_RESET);
        1: apply_gains(15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff);
        2: apply_gains(15'd0, 15'd0, 15'd0, 15'($urandom));
        3: apply_gains(15'($urandom), 15'($urandom), 15'($urandom), 15'd0);
        4: apply_gains(15'($urandom_range(0, 4000)), 15'($urandom_range(0, 400)),
                       15'($urandom_range(0, 400)), 15'($urandom_range(1000, 32767)));
        6: apply_gains(15'($urandom_range(0, 4000)), 15'($urandom_range(0, 400)),
                       15'($urandom_range(0, 400)), 15'h7fff);
        default: apply_gains(15'($urandom), 15'($urandom), 15'($urandom), 15'($urandom));
      endcase
      pause_at = $urandom_range(20, PHASE_ITEMS - 20);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == pause_at)
          wait_idle();
        next_sample(tgt, meas);
        send_speed(tgt, meas, pick_gap());
      end
      wait_idle();
    end
    steady = 1'b0;

    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
